// ===== hdl/stw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stw_pkg
// Shared types and fixed constants of the shift/xor word generator.
// ----------------------------------------------------------------------------
package stw_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned HalfW  = 64;
  localparam int unsigned EntryW = 128;

  localparam logic [WordW-1:0] ChainMul   = 32'd1812433253;
  localparam int unsigned      ChainShift = 30;
  localparam int unsigned      ShlA       = 1;
  localparam int unsigned      ShlB       = 5;
  localparam int unsigned      ShrA       = 14;

  localparam logic CmdDraw   = 1'b0;
  localparam logic CmdReseed = 1'b1;

  // commands from the controller to the datapath
  typedef struct packed {
    logic seed_load;  // latch seed, clear counter
    logic seed_step;  // one word of the init chain
    logic out_zero;   // unseeded draw result
    logic rd_pos;     // read entry at read position
    logic out_word;   // register drawn word, advance position
    logic rf_pre;     // read last entry, clear counter
    logic rf_q;       // capture last entry as previous
    logic rf_rd;      // read entry i and its lag partner
    logic rf_wr;      // update entry i
  } stw_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic seeded;
    logic pos_full;
    logic seed_last;
    logic rf_last;
  } stw_stat_t;

endpackage

// ===== hdl/simd_twister_random_words.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// simd_twister_random_words
// 32-bit word generator on a 128-bit shift/xor recursion, reseed and draw.
// ----------------------------------------------------------------------------
// draw: done follows the store read and the word select, or is registered at
//   the accept edge when unseeded; busy drops with the done cycle
// refill before a draw when all words are used: the RF_PRE and RF_Q states, then
//   a read state and an update state per entry on the single store
// reseed: one init chain multiply per word, no result
// rst resets the sequencer, sets the position to full and clears the seeded flag;
// the store is not cleared; results come as one-cycle done pulses that the receiver cannot stall
module simd_twister_random_words #(
  parameter int unsigned ENTRIES = 156,
  parameter int unsigned LAG     = 71
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        command,
  input  logic [31:0] seed,
  output logic        done,
  output logic [31:0] random_word,
  output logic        seeded
);

  stw_pkg::stw_cmd_t  cmd;
  stw_pkg::stw_stat_t stat;

  stw_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .stat    (stat),
    .busy    (busy),
    .done    (done),
    .cmd     (cmd)
  );

  stw_datapath #(
    .ENTRIES (ENTRIES),
    .LAG     (LAG)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .seed        (seed),
    .cmd         (cmd),
    .stat        (stat),
    .random_word (random_word),
    .seeded      (seeded)
  );

endmodule

// ===== hdl/stw_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stw_ctrl
// Sequencer for reseed, refill and draw of the word generator.
// ----------------------------------------------------------------------------
module stw_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               command,
  input  stw_pkg::stw_stat_t stat,
  output logic               busy,
  output logic               done,
  output stw_pkg::stw_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SEED   = 3'd1;
  localparam logic [2:0] S_RD     = 3'd2;
  localparam logic [2:0] S_OUT    = 3'd3;
  localparam logic [2:0] S_RF_PRE = 3'd4;
  localparam logic [2:0] S_RF_Q   = 3'd5;
  localparam logic [2:0] S_RF_RD  = 3'd6;
  localparam logic [2:0] S_RF_WR  = 3'd7;

  logic [2:0] state, state_next;
  logic       done_next;

  always_comb begin
    state_next = state;
    done_next  = 1'b0;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (command == stw_pkg::CmdReseed) begin
            cmd.seed_load = 1'b1;
            state_next    = S_SEED;
          end else if (!stat.seeded) begin
            cmd.out_zero = 1'b1;
            done_next    = 1'b1;
          end else if (stat.pos_full) begin
            state_next = S_RF_PRE;
          end else begin
            state_next = S_RD;
          end
        end
      end
      S_SEED: begin
        cmd.seed_step = 1'b1;
        if (stat.seed_last) begin
          state_next = S_IDLE;
        end
      end
      S_RD: begin
        cmd.rd_pos = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        cmd.out_word = 1'b1;
        done_next    = 1'b1;
        state_next   = S_IDLE;
      end
      S_RF_PRE: begin
        cmd.rf_pre = 1'b1;
        state_next = S_RF_Q;
      end
      S_RF_Q: begin
        cmd.rf_q   = 1'b1;
        state_next = S_RF_RD;
      end
      S_RF_RD: begin
        cmd.rf_rd  = 1'b1;
        state_next = S_RF_WR;
      end
      S_RF_WR: begin
        cmd.rf_wr = 1'b1;
        // last entry done: position is back at zero, go read
        state_next = stat.rf_last ? S_RD : S_RF_RD;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  assign busy = (state != S_IDLE);

endmodule

// ===== hdl/stw_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stw_datapath
// Entry store, init chain multiplier, refill recursion and word select.
// ----------------------------------------------------------------------------
module stw_datapath #(
  parameter int unsigned ENTRIES = 156,
  parameter int unsigned LAG     = 71
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [stw_pkg::WordW-1:0]        seed,
  input  stw_pkg::stw_cmd_t                cmd,
  output stw_pkg::stw_stat_t               stat,
  output logic [stw_pkg::WordW-1:0]        random_word,
  output logic                             seeded
);

  localparam int unsigned WORDS   = 4 * ENTRIES;
  localparam int unsigned CW      = $clog2(WORDS + 1);
  localparam int unsigned EW      = $clog2(ENTRIES);
  localparam int unsigned LAG_MOD = LAG % ENTRIES;

  localparam int unsigned WW = stw_pkg::WordW;
  localparam int unsigned HW = stw_pkg::HalfW;
  localparam int unsigned NW = stw_pkg::EntryW;

  logic [NW-1:0] store [ENTRIES];
  logic [NW-1:0] rd_a, rd_b;
  logic [EW-1:0] addr_a, addr_w;
  logic [NW-1:0] data_w;
  logic          we;

  logic [CW-1:0] cnt;
  logic [EW-1:0] p_idx;
  logic [CW-1:0] pos;
  logic          seeded_flag;
  logic [WW-1:0] seed_reg;
  logic [WW-1:0] w;
  logic [WW-1:0] w_next;
  logic [WW-1:0] w_mix;
  logic [3*WW-1:0] lane_buf;
  logic [NW-1:0] q;
  logic [HW-1:0] x0n, x1n;

  // init chain word for the current counter value
  always_comb begin
    w_mix  = w ^ (w >> stw_pkg::ChainShift);
    w_next = (cnt == '0) ? seed_reg
                         : WW'(stw_pkg::ChainMul * w_mix) + WW'(cnt);
  end

  // refill recursion; second half uses the updated first half
  always_comb begin
    x0n = rd_a[HW-1:0] ^ (rd_a[HW-1:0] << stw_pkg::ShlA)
        ^ rd_b[HW-1:0] ^ (rd_b[NW-1:HW] >> stw_pkg::ShrA)
        ^ q[HW-1:0] ^ (q[NW-1:HW] << stw_pkg::ShlB);
    x1n = rd_a[NW-1:HW] ^ (x0n << stw_pkg::ShlA)
        ^ rd_b[NW-1:HW] ^ (rd_b[HW-1:0] >> stw_pkg::ShrA)
        ^ q[NW-1:HW] ^ (q[HW-1:0] << stw_pkg::ShlB);
  end

  always_comb begin
    if (cmd.rf_rd) begin
      addr_a = cnt[EW-1:0];
    end else if (cmd.rf_pre) begin
      addr_a = EW'(ENTRIES - 1);
    end else if (cmd.rd_pos) begin
      addr_a = pos[EW+1:2];
    end else begin
      addr_a = '0;
    end
    if (cmd.rf_wr) begin
      addr_w = cnt[EW-1:0];
      data_w = {x1n, x0n};
      we     = 1'b1;
    end else begin
      addr_w = cnt[EW+1:2];
      data_w = {w_next, lane_buf};
      we     = cmd.seed_step && (cnt[1:0] == 2'd3);
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      store[addr_w] <= data_w;
    end
    rd_a <= store[addr_a];
    rd_b <= store[p_idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.seed_load) begin
      seed_reg <= seed;
      cnt      <= '0;
    end else if (cmd.seed_step || cmd.rf_wr) begin
      cnt <= cnt + 1'b1;
    end else if (cmd.rf_pre) begin
      cnt <= '0;
    end
    if (cmd.seed_step) begin
      w <= w_next;
      case (cnt[1:0])
        2'd0:    lane_buf[WW-1:0]      <= w_next;
        2'd1:    lane_buf[2*WW-1:WW]   <= w_next;
        2'd2:    lane_buf[3*WW-1:2*WW] <= w_next;
        default: lane_buf              <= lane_buf;
      endcase
    end
    if (cmd.rf_pre) begin
      p_idx <= EW'(LAG_MOD);
    end else if (cmd.rf_wr) begin
      p_idx <= (p_idx == EW'(ENTRIES - 1)) ? '0 : p_idx + 1'b1;
    end
    if (cmd.rf_q) begin
      q <= rd_a;
    end else if (cmd.rf_wr) begin
      q <= {x1n, x0n};
    end
    if (cmd.out_zero) begin
      random_word <= '0;
      seeded      <= 1'b0;
    end else if (cmd.out_word) begin
      random_word <= rd_a[pos[1:0]*WW +: WW];
      seeded      <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= CW'(WORDS);
      seeded_flag <= 1'b0;
    end else begin
      if (cmd.seed_step && stat.seed_last) begin
        pos         <= CW'(WORDS);
        seeded_flag <= 1'b1;
      end else if (cmd.rf_wr && stat.rf_last) begin
        pos <= '0;
      end else if (cmd.out_word) begin
        pos <= pos + 1'b1;
      end
    end
  end

  assign stat.seeded    = seeded_flag;
  assign stat.pos_full  = (pos >= CW'(WORDS));
  assign stat.seed_last = (cnt == CW'(WORDS - 1));
  assign stat.rf_last   = (cnt == CW'(ENTRIES - 1));

endmodule

// ===== hdl/stw_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stw_check
// Port-level checks on the word generator, bound to the top level.
// ----------------------------------------------------------------------------
module stw_check (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        command,
  input logic        done,
  input logic [31:0] random_word,
  input logic        seeded
);

  // a result never overlaps work in progress
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done while busy");

  // unseeded results carry a zero word
  a_unseeded_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !seeded) |-> (random_word == 32'd0))
    else $error("unseeded result not zero");

  // an accepted reseed makes the block busy while it fills the store
  a_reseed_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && command) |=> busy)
    else $error("reseed did not go busy");

  // no result without an accepted draw or work behind it
  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) || $past(start && !command)))
    else $error("result without draw");

endmodule

bind simd_twister_random_words stw_check u_stw_check (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .command     (command),
  .done        (done),
  .random_word (random_word),
  .seeded      (seeded)
);
